/* rtl/core/stbs_pkg.sv */
// Types and codes shared by the sorted table with binary search.
package stbs_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_SHUP,
		FSM_SHDN,
		FSM_RDW,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [5:0]  index;
	} req_item_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  position;
		logic [31:0] read_value;
		logic [6:0]  count;
		logic        empty_res;
	} rsp_item_t;

endpackage

/* rtl/core/sorted_table_binary_search_top.sv */
// Sorted table with binary search: sequencer, entry memory and result register.
//
//  channel | signals                  | direction | payload
//  --------+--------------------------+-----------+-------------------------------
//  req     | req_valid, req_stall     | in        | kind, value, index
//  rsp     | rsp_valid, rsp_stall     | out       | status, position, read_value,
//          |                          |           | count, empty_res
//
// One item is worked at a time; the memory has one read and one write port.
// Search compares the entry at the midpoint of a narrowing range, then loads the
// result. Insert then shifts the entries from the count down to the position and
// writes the value; remove moves the entries above the hit one place lower; read
// fetches the entry. Reset clears the count only; entries above it are unused.
// A new item is taken while a result still waits in the result register; a result
// stalls only if that register is full.
module sorted_table_binary_search_top
	import stbs_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int ZW = CW + 1;
	localparam int XW = (CW > 6) ? CW : 6;

	// entry memory
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata;
	logic [AW-1:0]         ra;
	logic                  we;
	logic [AW-1:0]         wa;
	logic [DATA_WIDTH-1:0] wd;

	// control state
	fsm_t          state_q, state_d;
	logic [CW-1:0] count_q;
	logic          wpend_q;
	logic          rsp_valid_q;

	// item and search registers
	kind_t                 kind_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic [CW-1:0]         lo_q, hi_q, mid_q, sp_q, pos_q;
	logic [AW-1:0]         wa_q;
	status_t               st_q;
	logic [DATA_WIDTH-1:0] rd_q;
	rsp_item_t             rsp_q;

	logic                  req_acc;
	logic                  rsp_load;
	logic [DATA_WIDTH-1:0] req_v;
	logic [CW-1:0]         first_mid;
	logic                  is_full;
	logic                  idx_bad;

	// search step
	logic          cmp_done, cmp_hit;
	logic [CW-1:0] cmp_pos, lo_n, hi_n, mid_n;
	logic          up_more, dn_more;

	assign req_stall = (state_q != FSM_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == FSM_RESP) && (!rsp_valid_q || !rsp_stall);

	assign req_v     = DATA_WIDTH'(req.value);
	assign first_mid = CW'((ZW'(count_q) - ZW'(1)) >> 1);
	assign is_full   = (count_q == CW'(CAPACITY));
	assign idx_bad   = (XW'(req.index) >= XW'(count_q));
	assign up_more   = (sp_q > pos_q);
	assign dn_more   = ((ZW'(sp_q) + ZW'(1)) < ZW'(count_q));

	// compare the entry read at mid and narrow the range
	always_comb begin
		cmp_done = 1'b0;
		cmp_hit  = 1'b0;
		cmp_pos  = mid_q;
		lo_n     = lo_q;
		hi_n     = hi_q;
		if (rdata == v_q) begin
			cmp_done = 1'b1;
			cmp_hit  = 1'b1;
		end else if (v_q > rdata) begin
			if (mid_q >= hi_q) begin
				cmp_done = 1'b1;
				cmp_pos  = hi_q + CW'(1);
			end else begin
				lo_n = mid_q + CW'(1);
			end
		end else begin
			if (mid_q <= lo_q) begin
				cmp_done = 1'b1;
				cmp_pos  = lo_q;
			end else begin
				hi_n = mid_q - CW'(1);
			end
		end
		mid_n = CW'((ZW'(lo_n) + ZW'(hi_n)) >> 1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req_acc) begin
					unique case (req.kind) inside
						KIND_INSERT: begin
							if (is_full)
								state_d = FSM_RESP;
							else if (count_q == '0)
								state_d = FSM_SHUP;
							else
								state_d = FSM_CMP;
						end
						KIND_SEARCH, KIND_REMOVE: begin
							state_d = (count_q == '0) ? FSM_RESP : FSM_CMP;
						end
						KIND_READ: begin
							state_d = idx_bad ? FSM_RESP : FSM_RDW;
						end
						default: state_d = FSM_IDLE;
					endcase
				end
			end
			FSM_CMP: begin
				if (cmp_done) begin
					unique case (kind_q)
						KIND_INSERT: state_d = FSM_SHUP;
						KIND_REMOVE: state_d = cmp_hit ? FSM_SHDN : FSM_RESP;
						default:     state_d = FSM_RESP;
					endcase
				end
			end
			FSM_SHUP: begin
				if (!up_more && !wpend_q)
					state_d = FSM_RESP;
			end
			FSM_SHDN: begin
				if (!dn_more)
					state_d = FSM_RESP;
			end
			FSM_RDW: begin
				state_d = FSM_RESP;
			end
			FSM_RESP: begin
				if (rsp_load)
					state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		ra = mid_q[AW-1:0];
		we = 1'b0;
		wa = wa_q;
		wd = rdata;
		unique case (state_q)
			FSM_IDLE: begin
				ra = (req.kind == KIND_READ) ? AW'(req.index) : first_mid[AW-1:0];
			end
			FSM_CMP: begin
				ra = mid_n[AW-1:0];
			end
			FSM_SHUP: begin
				ra = sp_q[AW-1:0] - AW'(1);
				if (wpend_q) begin
					we = 1'b1;
				end else if (!up_more) begin
					we = 1'b1;
					wa = pos_q[AW-1:0];
					wd = v_q;
				end
			end
			FSM_SHDN: begin
				ra = sp_q[AW-1:0] + AW'(1);
				we = wpend_q;
			end
			default: ra = mid_q[AW-1:0];
		endcase
	end

	// write and read the entry memory
	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rdata <= mem[ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			wpend_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				FSM_SHUP: begin
					wpend_q <= up_more;
					if (!up_more && !wpend_q)
						count_q <= count_q + CW'(1);
				end
				FSM_SHDN: begin
					wpend_q <= dn_more;
					if (!dn_more)
						count_q <= count_q - CW'(1);
				end
				default: wpend_q <= 1'b0;
			endcase
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// item, search and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			FSM_IDLE: begin
				if (req_acc) begin
					kind_q <= req.kind;
					v_q    <= req_v;
					lo_q   <= '0;
					hi_q   <= count_q - CW'(1);
					mid_q  <= first_mid;
					sp_q   <= count_q;
					pos_q  <= '0;
					rd_q   <= '0;
					st_q   <= ST_OK;
					unique case (req.kind) inside
						KIND_INSERT: if (is_full) st_q <= ST_FULL;
						KIND_SEARCH, KIND_REMOVE: if (count_q == '0) st_q <= ST_NOT_FOUND;
						KIND_READ: begin
							if (idx_bad)
								st_q <= ST_BAD_INDEX;
							else
								pos_q <= CW'(req.index);
						end
						default: st_q <= ST_OK;
					endcase
				end
			end
			FSM_CMP: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
				if (cmp_done) begin
					if (kind_q == KIND_INSERT || cmp_hit) begin
						pos_q <= cmp_pos;
					end else begin
						st_q <= ST_NOT_FOUND;
					end
					// insert shifts down from the count, remove up from the hit
					if (kind_q == KIND_REMOVE)
						sp_q <= cmp_pos;
				end
			end
			FSM_SHUP: begin
				if (up_more) begin
					wa_q <= sp_q[AW-1:0];
					sp_q <= sp_q - CW'(1);
				end
			end
			FSM_SHDN: begin
				if (dn_more) begin
					wa_q <= sp_q[AW-1:0];
					sp_q <= sp_q + CW'(1);
				end
			end
			FSM_RDW: begin
				rd_q <= rdata;
			end
			FSM_RESP: begin
				if (rsp_load) begin
					rsp_q.status     <= st_q;
					rsp_q.position   <= 7'(pos_q);
					rsp_q.read_value <= 32'(rd_q);
					rsp_q.count      <= 7'(count_q);
					rsp_q.empty_res  <= (count_q == '0);
				end
			end
			default: rd_q <= rd_q;
		endcase
	end

endmodule
